// ===== hdl/bbr_pkg.sv =====
// ---------------------------------------------------------------------------
// bbr_pkg: shared constants and types for the RGB box blur
// Holds configuration register indexes, reset values and the pixel type.
// ---------------------------------------------------------------------------
package bbr_pkg;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [3:0]  RADIUS_RESET = 4'd5;
    localparam logic [10:0] WIDTH_RESET  = 11'd600;
    localparam logic [10:0] HEIGHT_RESET = 11'd400;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

endpackage

// ===== hdl/bbr_ram.sv =====
// ---------------------------------------------------------------------------
// bbr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/bbr_div.sv =====
// ---------------------------------------------------------------------------
// bbr_div: iterative restoring divider for the three channel sums
// Divides three sums by one shared divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bbr_div #(
    parameter int SW = 20,
    parameter int DW = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [SW-1:0] num_r,
    input  logic [SW-1:0] num_g,
    input  logic [SW-1:0] num_b,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [7:0]    q_r,
    output logic [7:0]    q_g,
    output logic [7:0]    q_b
);

    localparam int CW = $clog2(SW + 1);

    logic [SW-1:0] nr_reg, ng_reg, nb_reg;
    logic [SW:0]   rr_reg, rg_reg, rb_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [SW:0]   tr, tg, tb;

    assign tr = {rr_reg[SW-1:0], nr_reg[SW-1]};
    assign tg = {rg_reg[SW-1:0], ng_reg[SW-1]};
    assign tb = {rb_reg[SW-1:0], nb_reg[SW-1]};
    assign done = busy_reg && (cnt_reg == '0);
    assign q_r = nr_reg[7:0];
    assign q_g = ng_reg[7:0];
    assign q_b = nb_reg[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(SW);
            nr_reg <= num_r; ng_reg <= num_g; nb_reg <= num_b;
            rr_reg <= '0; rg_reg <= '0; rb_reg <= '0;
            d_reg  <= divisor;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
                if (tr >= (SW+1)'(d_reg)) begin
                    rr_reg <= tr - (SW+1)'(d_reg);
                    nr_reg <= {nr_reg[SW-2:0], 1'b1};
                end else begin
                    rr_reg <= tr;
                    nr_reg <= {nr_reg[SW-2:0], 1'b0};
                end
                if (tg >= (SW+1)'(d_reg)) begin
                    rg_reg <= tg - (SW+1)'(d_reg);
                    ng_reg <= {ng_reg[SW-2:0], 1'b1};
                end else begin
                    rg_reg <= tg;
                    ng_reg <= {ng_reg[SW-2:0], 1'b0};
                end
                if (tb >= (SW+1)'(d_reg)) begin
                    rb_reg <= tb - (SW+1)'(d_reg);
                    nb_reg <= {nb_reg[SW-2:0], 1'b1};
                end else begin
                    rb_reg <= tb;
                    nb_reg <= {nb_reg[SW-2:0], 1'b0};
                end
            end
        end
    end

endmodule

// ===== hdl/box_blur_rgb.sv =====
// ---------------------------------------------------------------------------
// box_blur_rgb: box blur of an RGB pixel stream in raster order
// Line store in one RAM, window summed by a sequencer, mean by a divider.
// ---------------------------------------------------------------------------
// Each pixel is written into a line store of 2*MAX_RADIUS rows. Pixels whose
// window lies wholly inside the frame, last column and last row excepted,
// trigger a walk over the 2R-by-2R window, one line-store read per cycle
// through the single read port, followed by a restoring division of the three
// sums (one quotient bit per cycle). A pixel that gives no result leaves the
// input open. One that gives a result keeps the input closed while the block
// takes the pixel, makes 4*R*R reads, collects the last read, divides the
// SW-bit sums (SW is the sum width, 18 bits with the default MAX_RADIUS) and
// loads the output register. That last step waits while an earlier result is
// still unclaimed; once the result is loaded, the next pixel can be taken.
module box_blur_rgb
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic        s_tuser,   // first_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // col, row, red_out, green_out, blue_out
);

    localparam int ROWS = 2 * MAX_RADIUS;
    localparam int CWB  = $clog2(MAX_WIDTH);
    localparam int RWB  = $clog2(ROWS);
    localparam int DEPTH = ROWS * MAX_WIDTH;
    localparam int AW   = $clog2(DEPTH);
    localparam int KW   = $clog2(2 * MAX_RADIUS + 1);
    localparam int SW   = $clog2(4 * MAX_RADIUS * MAX_RADIUS * 255 + 1) + 1;
    localparam int DW   = $clog2(4 * MAX_RADIUS * MAX_RADIUS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_LAST = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [3:0]  radius_reg;
    logic [10:0] width_reg, height_reg;
    logic [11:0] col_reg, row_reg;
    logic [2:0]  state_reg;
    logic [KW-1:0] i_reg, j_reg;
    logic [11:0] ccol_reg, crow_reg;
    logic [SW-1:0] sr_reg, sg_reg, sb_reg;
    logic [4:0]  r_eff;
    logic [11:0] w_eff, h_eff;
    logic        rd_pend_reg;
    logic        start_div;
    logic        div_done;
    logic [7:0]  qr, qg, qb;
    logic [23:0] rd_data;
    logic [AW-1:0] wr_addr, rd_addr;
    logic        take;
    logic        emit;
    logic [11:0] r2m1;
    logic [11:0] cc_j;
    logic [RWB-1:0] row_mod;
    logic [RWB-1:0] row_mod_reg, crow_mod_reg;
    logic [RWB-1:0] rmod_now;
    logic [RWB:0]   row_sum;
    pixel_t      pix;

    always_comb begin
        if (radius_reg == 4'd0) r_eff = 5'd1;
        else if (32'(radius_reg) > MAX_RADIUS) r_eff = 5'(MAX_RADIUS);
        else r_eff = {1'b0, radius_reg};
        w_eff = (32'(width_reg) > MAX_WIDTH) ? 12'(MAX_WIDTH) : {1'b0, width_reg};
        h_eff = (32'(height_reg) > MAX_HEIGHT) ? 12'(MAX_HEIGHT) : {1'b0, height_reg};
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign take      = s_tvalid && s_tready;
    assign pix       = pixel_t'({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]});

    logic [11:0] c_now, r_now;
    assign c_now = s_tuser ? 12'd0 : col_reg;
    assign r_now = s_tuser ? 12'd0 : row_reg;
    assign r2m1  = {6'd0, r_eff, 1'b0} - 12'd1;
    assign emit  = (c_now >= r2m1) && (c_now + 12'd2 <= w_eff)
                 && (r_now >= r2m1) && (r_now + 12'd2 <= h_eff);

    // Store row is the frame row modulo the number of store rows, kept as a running count.
    assign rmod_now = s_tuser ? '0 : row_mod_reg;
    assign wr_addr  = AW'(32'(rmod_now) * MAX_WIDTH + 32'(c_now[CWB-1:0]));
    assign cc_j     = ccol_reg - 12'(j_reg);
    // Rows above the current pixel's row wrap back past store row 0 to the last store row.
    assign row_sum  = (RWB+1)'(crow_mod_reg) - (RWB+1)'(i_reg)
                    + ((32'(i_reg) > 32'(crow_mod_reg)) ? (RWB+1)'(ROWS) : '0);
    assign row_mod  = RWB'(row_sum);
    assign rd_addr  = AW'(32'(row_mod) * MAX_WIDTH + 32'(cc_j[CWB-1:0]));

    bbr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (take),
        .wr_addr (wr_addr),
        .wr_data (pix),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [DW-1:0] divisor;
    assign divisor = DW'(32'(r_eff) * 32'(r_eff) * 4);
    assign start_div = (state_reg == ST_LAST) && !rd_pend_reg;

    bbr_div #(.SW(SW), .DW(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_div),
        .num_r   (sr_reg),
        .num_g   (sg_reg),
        .num_b   (sb_reg),
        .divisor (divisor),
        .done    (div_done),
        .q_r     (qr),
        .q_g     (qg),
        .q_b     (qb)
    );

    logic [KW-1:0] r2;
    assign r2 = KW'({r_eff, 1'b0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            row_mod_reg <= '0;
            state_reg  <= ST_IDLE;
            m_tvalid   <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_RADIUS: radius_reg <= cfg_data[3:0];
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        if (c_now + 12'd1 >= w_eff) begin
                            col_reg <= '0;
                            if (r_now + 12'd1 >= h_eff) begin
                                row_reg     <= '0;
                                row_mod_reg <= '0;
                            end else begin
                                row_reg     <= r_now + 12'd1;
                                row_mod_reg <= (rmod_now == RWB'(ROWS - 1)) ? '0
                                                                            : rmod_now + 1'b1;
                            end
                        end else begin
                            col_reg <= c_now + 12'd1;
                            row_reg <= r_now;
                            row_mod_reg <= rmod_now;
                        end
                        if (emit) begin
                            ccol_reg <= c_now;
                            crow_reg <= r_now;
                            crow_mod_reg <= rmod_now;
                            i_reg <= '0;
                            j_reg <= '0;
                            sr_reg <= '0; sg_reg <= '0; sb_reg <= '0;
                            rd_pend_reg <= 1'b0;
                            state_reg <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    // Read address issued now; data of the previous one accumulates.
                    if (rd_pend_reg) begin
                        sr_reg <= sr_reg + SW'(rd_data[23:16]);
                        sg_reg <= sg_reg + SW'(rd_data[15:8]);
                        sb_reg <= sb_reg + SW'(rd_data[7:0]);
                    end
                    rd_pend_reg <= 1'b1;
                    if (j_reg + 1'b1 == r2) begin
                        j_reg <= '0;
                        if (i_reg + 1'b1 == r2) state_reg <= ST_LAST;
                        else i_reg <= i_reg + 1'b1;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_LAST: begin
                    if (rd_pend_reg) begin
                        sr_reg <= sr_reg + SW'(rd_data[23:16]);
                        sg_reg <= sg_reg + SW'(rd_data[15:8]);
                        sb_reg <= sb_reg + SW'(rd_data[7:0]);
                        rd_pend_reg <= 1'b0;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid || m_tready) begin
                        m_tvalid <= 1'b1;
                        m_tdata  <= {4'd0, qb, qg, qr,
                                     10'(crow_reg - 12'(r_eff) + 12'd1),
                                     10'(ccol_reg - 12'(r_eff) + 12'd1)};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
